[rtl/ile_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed list engine package
// Shared widths, operation and status codes, and the control word that the
// controller broadcasts to every cell of the list.
// ----------------------------------------------------------------------------
package ile_pkg;

   localparam int DATA_W   = 64;
   localparam int POS_W    = 8;
   localparam int REQ_W    = 4;
   localparam int STATUS_W = 2;
   // Wide enough to hold any index or count up to the largest capacity.
   localparam int KEY_W    = 9;
   // Cells per gather group for reads and for the first-match search.
   localparam int GRP_W    = 8;

   typedef enum logic [REQ_W-1:0] {
      OP_PUSH_FRONT  = 4'd0,
      OP_PUSH_BACK   = 4'd1,
      OP_POP_FRONT   = 4'd2,
      OP_POP_BACK    = 4'd3,
      OP_INSERT_AT   = 4'd4,
      OP_REMOVE_AT   = 4'd5,
      OP_REMOVE_VAL  = 4'd6,
      OP_READ_FRONT  = 4'd7,
      OP_READ_BACK   = 4'd8,
      OP_READ_AT     = 4'd9
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_EMPTY     = 2'd1,
      STS_FULL      = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CM_HOLD,
      CM_OPEN,
      CM_CLOSE,
      CM_CLOSE_HIT
   } cell_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FIN
   } state_type;

   typedef struct packed {
      cell_mode_type     mode;
      logic [KEY_W-1:0]  key;
      logic [KEY_W-1:0]  limit;
      logic [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

[rtl/ile_intf.sv]
// ----------------------------------------------------------------------------
// Indexed list engine channels
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface ile_req_if;
   import ile_pkg::*;

   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [POS_W-1:0]    position;
   logic signed [DATA_W-1:0] list_value;

   modport source (output valid, output req_type, output position, output list_value,
                   input ready);
   modport sink   (input valid, input req_type, input position, input list_value,
                   output ready);
endinterface

interface ile_rsp_if #(parameter int COUNT_W = 7);
   import ile_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_data;
   logic [COUNT_W-1:0]       item_count;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, output read_data, output item_count, output status,
                   input ready);
   modport sink   (input valid, input read_data, input item_count, input status,
                   output ready);
endinterface

[rtl/ile_cell.sv]
// ----------------------------------------------------------------------------
// Indexed list engine cell
// Holds one list entry. Each cycle it keeps its value, takes its lower or
// upper neighbor's value, or loads the broadcast value, as the control word
// and its own position decide. It also flags a value match and offers its
// entry when its position is the one being read.
// ----------------------------------------------------------------------------
module ile_cell #(
   parameter int IDX = 0
) (
   input  logic                         clock,
   input  ile_pkg::cell_ctl_type        ctl,
   input  logic [ile_pkg::DATA_W-1:0]   prev_data,
   input  logic [ile_pkg::DATA_W-1:0]   next_data,
   input  logic                         take_next,
   output logic [ile_pkg::DATA_W-1:0]   data,
   output logic                         hit,
   output logic [ile_pkg::DATA_W-1:0]   pick_data
);
   import ile_pkg::*;

   localparam logic [KEY_W-1:0] MY_IDX = KEY_W'(IDX);

   logic [DATA_W-1:0] data_ff, data_in;
   logic              hit_ff, hit_in;

   always_comb begin
      unique case (ctl.mode)
         CM_OPEN: begin
            if (MY_IDX > ctl.key) begin
               data_in = prev_data;
            end else if (MY_IDX == ctl.key) begin
               data_in = ctl.value;
            end else begin
               data_in = data_ff;
            end
         end
         CM_CLOSE:     data_in = (MY_IDX >= ctl.key) ? next_data : data_ff;
         CM_CLOSE_HIT: data_in = take_next ? next_data : data_ff;
         default:      data_in = data_ff;
      endcase
   end

   // Only cells that hold a live entry may report a match.
   assign hit_in = (MY_IDX < ctl.limit) && (data_ff == ctl.value);

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data      = data_ff;
   assign hit       = hit_ff;
   assign pick_data = (MY_IDX == ctl.key) ? data_ff : '0;

endmodule

[rtl/indexed_list_engine_top.sv]
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed 64-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request: req_type, position and list_value. Every
//   request produces exactly one response on rsp_chan with read_data,
//   item_count (elements held afterwards) and status.
//   A request is taken in the idle state. The next cycle evaluates it: each
//   cell compares its entry with list_value and the read entry is gathered
//   into group registers. The finish state then commits the shift in all
//   cells at once and loads the response register, which drives rsp_chan.valid.
//   No new request is taken until the previous one has gone through the
//   evaluate and commit passes over the cell row.
//   A new request is accepted while an earlier response still waits; if the
//   receiver stalls, the commit waits until the response register frees up,
//   and the list does not change in the meantime.
//   Reset empties the list and drops any pending response. Entry contents are
//   not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_list_engine_top #(
   parameter int CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   ile_req_if.sink    req_chan,
   ile_rsp_if.source  rsp_chan
);
   import ile_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int NGRP = (CAPACITY + GRP_W - 1) / GRP_W;
   localparam logic [KEY_W-1:0] CAP_KEY = KEY_W'(CAPACITY);

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [DATA_W-1:0]     val_ff, val_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]     grp_ff [NGRP];
   logic [DATA_W-1:0]     grp_in [NGRP];

   cell_ctl_type          ctl;
   logic [DATA_W-1:0]     cell_data [CAPACITY];
   logic [DATA_W-1:0]     cell_pick [CAPACITY];
   logic [CAPACITY-1:0]   cell_hit;
   logic [CAPACITY-1:0]   take;
   logic                  any_hit;

   logic [KEY_W-1:0]      cnt_key, pos_key, rd_key;
   logic                  pos_lt, is_full, is_empty, load;
   logic [DATA_W-1:0]     rd_data;
   cell_mode_type         dec_mode;
   logic [KEY_W-1:0]      dec_key;
   logic [CW-1:0]         dec_count;
   status_type            dec_status;
   logic [DATA_W-1:0]     dec_data;

   // ------------------------------------------------------------------
   // Cell row
   // ------------------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] lo_data, hi_data;
      if (i == 0) begin : g_first
         assign lo_data = cell_data[i];
      end else begin : g_mid_lo
         assign lo_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign hi_data = cell_data[i];
      end else begin : g_mid_hi
         assign hi_data = cell_data[i+1];
      end

      ile_cell #(.IDX(i)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .prev_data (lo_data),
         .next_data (hi_data),
         .take_next (take[i]),
         .data      (cell_data[i]),
         .hit       (cell_hit[i]),
         .pick_data (cell_pick[i])
      );
   end

   // ------------------------------------------------------------------
   // Gather of the read entry, registered per group of cells
   // ------------------------------------------------------------------
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < GRP_W; j++) begin
            if (g * GRP_W + j < CAPACITY) begin
               grp_in[g] = grp_in[g] | cell_pick[g * GRP_W + j];
            end
         end
      end
   end

   always_comb begin
      rd_data = '0;
      for (int g = 0; g < NGRP; g++) begin
         rd_data = rd_data | grp_ff[g];
      end
   end

   // ------------------------------------------------------------------
   // First match: a cell shifts down when it or any cell below it matched.
   // ------------------------------------------------------------------
   always_comb begin
      logic below;
      logic run;
      logic grp_any;
      below = 1'b0;
      run   = 1'b0;
      take  = '0;
      for (int g = 0; g < NGRP; g++) begin
         run     = below;
         grp_any = 1'b0;
         for (int j = 0; j < GRP_W; j++) begin
            if (g * GRP_W + j < CAPACITY) begin
               run                = run | cell_hit[g * GRP_W + j];
               grp_any            = grp_any | cell_hit[g * GRP_W + j];
               take[g * GRP_W + j] = run;
            end
         end
         below = below | grp_any;
      end
      any_hit = below;
   end

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   assign cnt_key  = KEY_W'(count_ff);
   assign pos_key  = KEY_W'(pos_ff);
   assign pos_lt   = pos_key < cnt_key;
   assign is_full  = cnt_key == CAP_KEY;
   assign is_empty = count_ff == '0;

   always_comb begin
      unique case (op_ff)
         OP_READ_BACK: rd_key = cnt_key - KEY_W'(1);
         OP_READ_AT:   rd_key = pos_key;
         default:      rd_key = '0;
      endcase
   end

   always_comb begin
      dec_mode   = CM_HOLD;
      dec_key    = '0;
      dec_count  = count_ff;
      dec_status = STS_OK;
      dec_data   = '0;
      unique case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
            if (is_full) begin
               dec_status = STS_FULL;
            end else begin
               dec_mode  = CM_OPEN;
               dec_count = count_ff + CW'(1);
               if (op_ff == OP_PUSH_FRONT) begin
                  dec_key = '0;
               end else if (op_ff == OP_PUSH_BACK || !pos_lt) begin
                  dec_key = cnt_key;
               end else begin
                  dec_key = pos_key;
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
            if (is_empty) begin
               dec_status = STS_EMPTY;
            end else begin
               dec_mode  = CM_CLOSE;
               dec_count = count_ff - CW'(1);
               if (op_ff == OP_POP_FRONT) begin
                  dec_key = '0;
               end else if (op_ff == OP_POP_BACK || !pos_lt) begin
                  dec_key = cnt_key - KEY_W'(1);
               end else begin
                  dec_key = pos_key;
               end
            end
         end
         OP_REMOVE_VAL: begin
            if (is_empty) begin
               dec_status = STS_EMPTY;
            end else if (any_hit) begin
               dec_mode  = CM_CLOSE_HIT;
               dec_count = count_ff - CW'(1);
            end else begin
               dec_status = STS_NOT_FOUND;
            end
         end
         OP_READ_FRONT, OP_READ_BACK: begin
            if (is_empty) begin
               dec_status = STS_EMPTY;
            end else begin
               dec_data = rd_data;
            end
         end
         OP_READ_AT: begin
            if (pos_lt) begin
               dec_data = rd_data;
            end else begin
               dec_status = STS_EMPTY;
            end
         end
         default: begin
            dec_status = STS_OK;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Controller
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      load          = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      ctl.mode      = CM_HOLD;
      ctl.key       = rd_key;
      ctl.limit     = cnt_key;
      ctl.value     = val_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in    = op_type'(req_chan.req_type);
               pos_in   = req_chan.position;
               val_in   = req_chan.list_value;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load          = 1'b1;
               ctl.mode      = dec_mode;
               ctl.key       = dec_key;
               count_in      = dec_count;
               rsp_valid_in  = 1'b1;
               rsp_data_in   = dec_data;
               rsp_count_in  = dec_count;
               rsp_status_in = dec_status;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      for (int g = 0; g < NGRP; g++) begin
         grp_ff[g] <= grp_in[g];
      end
   end

   assign req_chan.ready      = state_ff == ST_IDLE;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_data  = rsp_data_ff;
   assign rsp_chan.item_count = rsp_count_ff;
   assign rsp_chan.status     = rsp_status_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   assert property (@(posedge clock) disable iff (reset)
      KEY_W'(count_ff) <= CAP_KEY)
      else $error("list count exceeds capacity");

   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_EVAL))
      else $error("accepted request did not enter evaluation");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STS_FULL) |-> (KEY_W'(rsp_count_ff) == CAP_KEY))
      else $error("full status reported on a list that is not full");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff != '0) |-> (rsp_status_ff == STS_OK))
      else $error("read data returned with an error status");

   assert property (@(posedge clock) disable iff (reset)
      load |=> (KEY_W'(count_ff) == KEY_W'(rsp_count_ff)))
      else $error("response count differs from list count");

endmodule
